// ===== hdl/ordered_list_with_compaction_defines.svh =====
// Assertion macros used by the list top module.
`ifndef ORDERED_LIST_WITH_COMPACTION_DEFINES_SVH
`define ORDERED_LIST_WITH_COMPACTION_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define OLC_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("list assertion failed");

// Next-cycle implication, checked outside reset.
`define OLC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("list assertion failed");

`endif

// ===== hdl/olc_pkg.sv =====
`default_nettype none

package olc_pkg;

    localparam int DEPTH_DEF    = 16;
    localparam int KEY_BITS_DEF = 32;
    localparam int CAP_BITS     = 5;
    localparam int ACTION_BITS  = 2;

    localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd10;

    typedef enum logic [ACTION_BITS-1:0] {
        ACT_APPEND = 2'd0,
        ACT_READ   = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    // Program addresses of the control store.
    typedef enum logic [3:0] {
        P_IDLE,
        P_DISPATCH,
        P_CHK_READ,
        P_CHK_REMOVE,
        P_APPEND,
        P_APP_WRITE,
        P_READ,
        P_READ_CAP,
        P_SCAN_INIT,
        P_SCAN,
        P_SCAN_CMP,
        P_SHIFT,
        P_SHIFT_WRITE,
        P_REM_DONE,
        P_FAIL,
        P_FINISH
    } pc_t;

    typedef enum logic [3:0] {
        C_ALWAYS,
        C_ACCEPT,
        C_ACT_APPEND,
        C_ACT_READ,
        C_ACT_REMOVE,
        C_FULL,
        C_IDX_BAD,
        C_PTR_END,
        C_MATCH,
        C_OUT_BUSY
    } cond_t;

    typedef enum logic {
        RS_INDEX,
        RS_PTR
    } rd_sel_t;

    typedef enum logic {
        WS_TAIL,
        WS_SHIFT
    } wr_sel_t;

    typedef enum logic [1:0] {
        PTR_HOLD,
        PTR_CLR,
        PTR_INC
    } ptr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC
    } cnt_op_t;

    typedef enum logic [1:0] {
        RES_HOLD,
        RES_OK,
        RES_READ,
        RES_FAIL
    } res_op_t;

    typedef struct packed {
        cond_t   cond;
        pc_t     jmp;
        pc_t     nxt;
        logic    s_ready;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    we;
        wr_sel_t wr_sel;
        ptr_op_t ptr_op;
        cnt_op_t cnt_op;
        res_op_t res_op;
        logic    out_load;
    } ctrl_t;

    typedef struct packed {
        logic accept;
        logic act_append;
        logic act_read;
        logic act_remove;
        logic full;
        logic idx_bad;
        logic ptr_end;
        logic match;
        logic out_busy;
    } flags_t;

    // Control store. A word jumps to jmp when its condition holds, else to nxt.
    function automatic ctrl_t ucode(pc_t pc);
        ctrl_t w;
        w.cond     = C_ALWAYS;
        w.jmp      = P_IDLE;
        w.nxt      = P_IDLE;
        w.s_ready  = 1'b0;
        w.rd_en    = 1'b0;
        w.rd_sel   = RS_INDEX;
        w.we       = 1'b0;
        w.wr_sel   = WS_TAIL;
        w.ptr_op   = PTR_HOLD;
        w.cnt_op   = CNT_HOLD;
        w.res_op   = RES_HOLD;
        w.out_load = 1'b0;
        unique case (pc)
            P_IDLE: begin
                w.cond    = C_ACCEPT;
                w.jmp     = P_DISPATCH;
                w.nxt     = P_IDLE;
                w.s_ready = 1'b1;
            end
            P_DISPATCH: begin
                w.cond = C_ACT_APPEND;
                w.jmp  = P_APPEND;
                w.nxt  = P_CHK_READ;
            end
            P_CHK_READ: begin
                w.cond = C_ACT_READ;
                w.jmp  = P_READ;
                w.nxt  = P_CHK_REMOVE;
            end
            P_CHK_REMOVE: begin
                w.cond = C_ACT_REMOVE;
                w.jmp  = P_SCAN_INIT;
                w.nxt  = P_FAIL;
            end
            P_APPEND: begin
                w.cond = C_FULL;
                w.jmp  = P_FAIL;
                w.nxt  = P_APP_WRITE;
            end
            P_APP_WRITE: begin
                w.jmp    = P_FINISH;
                w.we     = 1'b1;
                w.wr_sel = WS_TAIL;
                w.cnt_op = CNT_INC;
                w.res_op = RES_OK;
            end
            P_READ: begin
                w.cond   = C_IDX_BAD;
                w.jmp    = P_FAIL;
                w.nxt    = P_READ_CAP;
                w.rd_en  = 1'b1;
                w.rd_sel = RS_INDEX;
            end
            P_READ_CAP: begin
                w.jmp    = P_FINISH;
                w.res_op = RES_READ;
            end
            P_SCAN_INIT: begin
                w.jmp    = P_SCAN;
                w.ptr_op = PTR_CLR;
            end
            P_SCAN: begin
                w.cond   = C_PTR_END;
                w.jmp    = P_FAIL;
                w.nxt    = P_SCAN_CMP;
                w.rd_en  = 1'b1;
                w.rd_sel = RS_PTR;
            end
            P_SCAN_CMP: begin
                // The pointer steps past the hit, so the shift starts reading there.
                w.cond   = C_MATCH;
                w.jmp    = P_SHIFT;
                w.nxt    = P_SCAN;
                w.ptr_op = PTR_INC;
            end
            P_SHIFT: begin
                w.cond   = C_PTR_END;
                w.jmp    = P_REM_DONE;
                w.nxt    = P_SHIFT_WRITE;
                w.rd_en  = 1'b1;
                w.rd_sel = RS_PTR;
            end
            P_SHIFT_WRITE: begin
                w.jmp    = P_SHIFT;
                w.we     = 1'b1;
                w.wr_sel = WS_SHIFT;
                w.ptr_op = PTR_INC;
            end
            P_REM_DONE: begin
                w.jmp    = P_FINISH;
                w.cnt_op = CNT_DEC;
                w.res_op = RES_OK;
            end
            P_FAIL: begin
                w.jmp    = P_FINISH;
                w.res_op = RES_FAIL;
            end
            P_FINISH: begin
                w.cond     = C_OUT_BUSY;
                w.jmp      = P_FINISH;
                w.nxt      = P_IDLE;
                w.out_load = 1'b1;
            end
            default: begin
                w.jmp = P_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/olc_seq.sv =====
`default_nettype none

module olc_seq (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire olc_pkg::flags_t flags,
    output olc_pkg::ctrl_t      ctrl
);
    import olc_pkg::*;

    pc_t  pc_reg;
    pc_t  pc_next;
    logic take;

    assign ctrl = ucode(pc_reg);

    always_comb begin
        unique case (ctrl.cond)
            C_ALWAYS:     take = 1'b1;
            C_ACCEPT:     take = flags.accept;
            C_ACT_APPEND: take = flags.act_append;
            C_ACT_READ:   take = flags.act_read;
            C_ACT_REMOVE: take = flags.act_remove;
            C_FULL:       take = flags.full;
            C_IDX_BAD:    take = flags.idx_bad;
            C_PTR_END:    take = flags.ptr_end;
            C_MATCH:      take = flags.match;
            C_OUT_BUSY:   take = flags.out_busy;
            default:      take = 1'b1;
        endcase
        pc_next = take ? ctrl.jmp : ctrl.nxt;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= P_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/ordered_list_with_compaction.sv =====
// Items are processed one at a time: a new input item is accepted only in the
// idle step, after the previous result has been loaded into the output register.
// A remove scans the entries with a read step and a compare step each, then
// compacts the list with a read step and a write-back step per later entry.
// Reset (synchronous, aresetn low) empties the list, sets capacity to 10 and
// returns the sequencer to idle; the entry store itself is not cleared.
`default_nettype none
`include "ordered_list_with_compaction_defines.svh"

module ordered_list_with_compaction #(
    parameter int DEPTH    = olc_pkg::DEPTH_DEF,
    parameter int KEY_BITS = olc_pkg::KEY_BITS_DEF,
    localparam int IDX_BITS  = $clog2(DEPTH),
    localparam int CNT_BITS  = $clog2(DEPTH + 1),
    localparam int S_DATA_W  = ((KEY_BITS + IDX_BITS + 7) / 8) * 8,
    localparam int M_DATA_W  = ((KEY_BITS + CNT_BITS + 2 + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // Input items.
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    // tdata fields from bit 0: key, index.
    input  wire logic [S_DATA_W-1:0]            s_tdata,
    // tuser fields from bit 0: action.
    input  wire logic [olc_pkg::ACTION_BITS-1:0] s_tuser,
    // Result items.
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    // tdata fields from bit 0: read_key, count, full_res, empty_res.
    output logic [M_DATA_W-1:0]                 m_tdata,
    // tuser fields from bit 0: status.
    output logic [0:0]                          m_tuser,
    // Capacity register write.
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [olc_pkg::CAP_BITS-1:0]    cfg_data
);
    import olc_pkg::*;

    localparam int CMP_BITS = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

    ctrl_t  ctrl;
    flags_t flags;

    logic [ACTION_BITS-1:0] act_reg;
    logic [KEY_BITS-1:0]    key_reg;
    logic [IDX_BITS-1:0]    idx_reg;
    logic [CNT_BITS-1:0]    cnt_reg;
    logic [CNT_BITS-1:0]    cnt_next;
    logic [CNT_BITS-1:0]    ptr_reg;
    logic [CNT_BITS-1:0]    ptr_next;
    logic [CNT_BITS-1:0]    ptr_prev;
    logic [CAP_BITS-1:0]    cap_reg;
    logic [KEY_BITS-1:0]    rd_data_reg;
    logic                   status_reg;
    logic [KEY_BITS-1:0]    rkey_reg;
    logic                   m_tvalid_reg;
    logic [M_DATA_W-1:0]    m_tdata_reg;
    logic                   m_status_reg;

    logic [KEY_BITS-1:0]    mem [DEPTH];
    logic [IDX_BITS-1:0]    rd_addr;
    logic [IDX_BITS-1:0]    wr_addr;
    logic [KEY_BITS-1:0]    wr_data;

    logic [CMP_BITS-1:0]    cap_ext;
    logic [CMP_BITS-1:0]    depth_ext;
    logic [CMP_BITS-1:0]    eff_cap;
    logic                   full_now;
    logic                   accept;
    logic                   out_busy;

    olc_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .flags   (flags),
        .ctrl    (ctrl)
    );

    assign s_tready  = ctrl.s_ready;
    assign cfg_ready = 1'b1;
    assign accept    = s_tvalid && s_tready;
    assign out_busy  = m_tvalid_reg && !m_tready;

    // Capacity above the store depth saturates to the depth.
    assign cap_ext   = CMP_BITS'(cap_reg);
    assign depth_ext = CMP_BITS'(DEPTH);
    assign eff_cap   = (cap_ext > depth_ext) ? depth_ext : cap_ext;
    assign full_now  = CMP_BITS'(cnt_reg) >= eff_cap;

    assign ptr_prev = ptr_reg - 1'b1;

    always_comb begin
        flags.accept     = accept;
        flags.act_append = (act_reg == ACT_APPEND);
        flags.act_read   = (act_reg == ACT_READ);
        flags.act_remove = (act_reg == ACT_REMOVE);
        flags.full       = full_now;
        flags.idx_bad    = CNT_BITS'(idx_reg) >= cnt_reg;
        flags.ptr_end    = ptr_reg >= cnt_reg;
        flags.match      = (rd_data_reg == key_reg);
        flags.out_busy   = out_busy;
    end

    always_comb begin
        unique case (ctrl.rd_sel)
            RS_INDEX: rd_addr = idx_reg;
            RS_PTR:   rd_addr = ptr_reg[IDX_BITS-1:0];
            default:  rd_addr = idx_reg;
        endcase
        unique case (ctrl.wr_sel)
            WS_TAIL: begin
                wr_addr = cnt_reg[IDX_BITS-1:0];
                wr_data = key_reg;
            end
            WS_SHIFT: begin
                wr_addr = ptr_prev[IDX_BITS-1:0];
                wr_data = rd_data_reg;
            end
            default: begin
                wr_addr = cnt_reg[IDX_BITS-1:0];
                wr_data = key_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_comb begin
        unique case (ctrl.ptr_op)
            PTR_HOLD: ptr_next = ptr_reg;
            PTR_CLR:  ptr_next = '0;
            PTR_INC:  ptr_next = ptr_reg + 1'b1;
            default:  ptr_next = ptr_reg;
        endcase
        unique case (ctrl.cnt_op)
            CNT_HOLD: cnt_next = cnt_reg;
            CNT_INC:  cnt_next = cnt_reg + 1'b1;
            CNT_DEC:  cnt_next = cnt_reg - 1'b1;
            default:  cnt_next = cnt_reg;
        endcase
    end

    // Item capture and working registers.
    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_tuser;
            key_reg <= s_tdata[KEY_BITS-1:0];
            idx_reg <= s_tdata[KEY_BITS +: IDX_BITS];
        end
        ptr_reg <= ptr_next;
        unique case (ctrl.res_op)
            RES_HOLD: ;
            RES_OK: begin
                status_reg <= 1'b0;
                rkey_reg   <= '0;
            end
            RES_READ: begin
                status_reg <= 1'b0;
                rkey_reg   <= rd_data_reg;
            end
            RES_FAIL: begin
                status_reg <= 1'b1;
                rkey_reg   <= '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            cap_reg <= CAP_RESET;
        end else begin
            cnt_reg <= cnt_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
        end
    end

    // Output register; the sequencer waits in its last step while a result is held.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (ctrl.out_load && !out_busy) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.out_load && !out_busy) begin
            m_status_reg <= status_reg;
            m_tdata_reg  <= M_DATA_W'({(cnt_reg == '0), full_now, cnt_reg, rkey_reg});
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_status_reg;

    `OLC_ASSERT_IMPLIES(a_cnt_bound, 1'b1, cnt_reg <= CNT_BITS'(DEPTH))
    `OLC_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready)
    `OLC_ASSERT_IMPLIES(a_tail_in_range, ctrl.we && ctrl.wr_sel == WS_TAIL, !full_now)

endmodule

`default_nettype wire

// ===== tb/sv/tb_ordered_list_with_compaction.sv =====
`default_nettype none

module tb_ordered_list_with_compaction;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH      = olc_pkg::DEPTH_DEF;
    localparam int KEY_BITS   = olc_pkg::KEY_BITS_DEF;
    localparam int IDX_BITS   = $clog2(DEPTH);
    localparam int CNT_BITS   = $clog2(DEPTH + 1);
    localparam int S_DATA_W   = ((KEY_BITS + IDX_BITS + 7) / 8) * 8;
    localparam int M_DATA_W   = ((KEY_BITS + CNT_BITS + 2 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 20;
    localparam int PHASE_ITEMS = 180;

    // The block's action field is two bits wide; the top code is unused.
    localparam logic [olc_pkg::ACTION_BITS-1:0] ACT_UNKNOWN = 2'd3;

    typedef struct packed {
        logic                status;
        logic [KEY_BITS-1:0] read_key;
        logic [CNT_BITS-1:0] count;
        logic                full_flag;
        logic                empty_flag;
    } list_result_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [S_DATA_W-1:0]                s_tdata;
    logic [olc_pkg::ACTION_BITS-1:0]    s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [M_DATA_W-1:0]                m_tdata;
    logic [0:0]                         m_tuser;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [olc_pkg::CAP_BITS-1:0]       cfg_data;

    // Shadow copy of the list, updated as each item is accepted.
    logic [KEY_BITS-1:0]          list_keys [DEPTH];
    int                           list_count;
    logic [olc_pkg::CAP_BITS-1:0] list_cap;

    list_result_t        pending_results [$];
    logic [KEY_BITS-1:0] key_pool [8];
    int                  error_count;
    int                  cycle_count;
    logic                no_idle;

    ordered_list_with_compaction #(
        .DEPTH    (DEPTH),
        .KEY_BITS (KEY_BITS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_ordered_list_with_compaction: done, errors");
            $finish;
        end
    end

    // The result side stays ready through reset and during quiet phases.
    always @(negedge aclk) begin
        if (aresetn !== 1'b1 || no_idle)
            m_tready <= 1'b1;
        else
            m_tready <= ($urandom_range(99) >= 7);
    end

    function automatic list_result_t list_apply(input logic [1:0] act,
                                                input logic [KEY_BITS-1:0] key,
                                                input logic [IDX_BITS-1:0] idx);
        list_result_t r;
        int hit;
        int eff_cap;
        r = '0;
        r.status = 1'b1;
        hit = -1;
        eff_cap = (list_cap > DEPTH) ? DEPTH : int'(list_cap);
        case (act)
            olc_pkg::ACT_APPEND: begin
                if (list_count < eff_cap) begin
                    list_keys[list_count] = key;
                    list_count++;
                    r.status = 1'b0;
                end
            end
            olc_pkg::ACT_READ: begin
                if (int'(idx) < list_count) begin
                    r.read_key = list_keys[idx];
                    r.status = 1'b0;
                end
            end
            olc_pkg::ACT_REMOVE: begin
                for (int i = 0; i < list_count; i++)
                    if (hit < 0 && list_keys[i] == key)
                        hit = i;
                if (hit >= 0) begin
                    for (int i = hit; i + 1 < list_count; i++)
                        list_keys[i] = list_keys[i + 1];
                    list_count--;
                    r.status = 1'b0;
                end
            end
            default: ;
        endcase
        r.count = CNT_BITS'(list_count);
        r.full_flag = (list_count >= eff_cap);
        r.empty_flag = (list_count == 0);
        return r;
    endfunction

    task automatic report_mismatch(input string field, input logic [KEY_BITS-1:0] got,
                                   input logic [KEY_BITS-1:0] want);
        $display("mismatch at cycle %0d, %s: got %0h, want %0h", cycle_count, field, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with nothing pending", m_tdata[KEY_BITS-1:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (m_tuser[0] !== want.status)
                    report_mismatch("status", KEY_BITS'(m_tuser[0]), KEY_BITS'(want.status));
                if (m_tdata[KEY_BITS-1:0] !== want.read_key)
                    report_mismatch("read_key", m_tdata[KEY_BITS-1:0], want.read_key);
                if (m_tdata[KEY_BITS+CNT_BITS-1:KEY_BITS] !== want.count)
                    report_mismatch("count", KEY_BITS'(m_tdata[KEY_BITS+CNT_BITS-1:KEY_BITS]),
                                    KEY_BITS'(want.count));
                if (m_tdata[KEY_BITS+CNT_BITS] !== want.full_flag)
                    report_mismatch("full_res", KEY_BITS'(m_tdata[KEY_BITS+CNT_BITS]),
                                    KEY_BITS'(want.full_flag));
                if (m_tdata[KEY_BITS+CNT_BITS+1] !== want.empty_flag)
                    report_mismatch("empty_res", KEY_BITS'(m_tdata[KEY_BITS+CNT_BITS+1]),
                                    KEY_BITS'(want.empty_flag));
            end
        end
    end

    // Called at a falling edge. Leaves s_tvalid high so back-to-back items do not
    // drop valid; whoever pauses the stream lowers it.
    task automatic send_item(input logic [1:0] act, input logic [KEY_BITS-1:0] key,
                             input logic [IDX_BITS-1:0] idx);
        while (!no_idle && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= S_DATA_W'({idx, key});
        do @(posedge aclk); while (!s_tready);
        pending_results.push_back(list_apply(act, key, idx));
        @(negedge aclk);
    endtask

    task automatic drain_and_settle();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [olc_pkg::CAP_BITS-1:0] cap);
        drain_and_settle();
        cfg_valid <= 1'b1;
        cfg_data  <= cap;
        do @(posedge aclk); while (!cfg_ready);
        list_cap = cap;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Fills up to the reset capacity, with one duplicate key for the
    // first-match check later, then overflows it.
    task automatic test_reset_capacity();
        send_item(olc_pkg::ACT_APPEND, '0, '0);
        send_item(olc_pkg::ACT_APPEND, '1, '1);
        send_item(olc_pkg::ACT_APPEND, 32'hA5A5_A5A5, 4'd3);
        for (int i = 3; i < 9; i++)
            send_item(olc_pkg::ACT_APPEND, 32'h1000_0000 + i, 4'(i));
        send_item(olc_pkg::ACT_APPEND, 32'hA5A5_A5A5, '0);
        send_item(olc_pkg::ACT_APPEND, 32'h5A5A_5A5A, '0);
    endtask

    // A capacity above the store depth acts as the depth. This also writes
    // every store entry, so no later access can touch an unwritten one.
    task automatic test_capacity_saturation();
        write_capacity(5'd31);
        for (int i = 10; i < DEPTH; i++)
            send_item(olc_pkg::ACT_APPEND, 32'h2000_0000 + i, 4'(i));
        send_item(olc_pkg::ACT_APPEND, 32'h5A5A_5A5A, '0);
    endtask

    task automatic test_edge_actions();
        send_item(olc_pkg::ACT_READ, '1, 4'd15);
        send_item(olc_pkg::ACT_READ, '0, 4'd0);
        send_item(olc_pkg::ACT_REMOVE, 32'hA5A5_A5A5, '1);
        send_item(olc_pkg::ACT_REMOVE, '0, '0);
        send_item(olc_pkg::ACT_REMOVE, 32'h2000_000F, '0);
        send_item(olc_pkg::ACT_REMOVE, 32'hDEAD_BEEF, '0);
        send_item(ACT_UNKNOWN, 32'hA5A5_A5A5, 4'd2);
        send_item(olc_pkg::ACT_READ, '0, 4'd15);
        // Zero capacity below the current count: the list is full, appends fail.
        write_capacity(5'd0);
        send_item(olc_pkg::ACT_APPEND, 32'h1234_5678, '0);
    endtask

    task automatic test_random_phase(input logic [olc_pkg::CAP_BITS-1:0] cap,
                                     input logic quiet, input int pause_every);
        int r;
        logic [1:0] act;
        logic [KEY_BITS-1:0] key;
        logic [IDX_BITS-1:0] idx;
        write_capacity(cap);
        no_idle = quiet;
        // A small key pool makes removes hit and duplicates common.
        for (int i = 0; i < 8; i++)
            key_pool[i] = $urandom();
        for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(99);
            if (r < 40)
                act = olc_pkg::ACT_APPEND;
            else if (r < 65)
                act = olc_pkg::ACT_READ;
            else if (r < 95)
                act = olc_pkg::ACT_REMOVE;
            else
                act = ACT_UNKNOWN;
            key = ($urandom_range(99) < 85) ? key_pool[$urandom_range(7)] : $urandom();
            if (list_count > 0 && $urandom_range(99) < 75)
                idx = IDX_BITS'($urandom_range(list_count - 1));
            else
                idx = IDX_BITS'($urandom());
            send_item(act, key, idx);
            if (pause_every > 0 && n % pause_every == pause_every - 1)
                drain_and_settle();
        end
        no_idle = 1'b0;
    endtask

    initial begin
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tuser     <= '0;
        cfg_valid   <= 1'b0;
        cfg_data    <= '0;
        no_idle     = 1'b0;
        error_count = 0;
        cycle_count = 0;
        list_count  = 0;
        list_cap    = olc_pkg::CAP_RESET;
        for (int i = 0; i < DEPTH; i++)
            list_keys[i] = '0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_reset_capacity();
        test_capacity_saturation();
        test_edge_actions();
        test_random_phase(5'd16, 1'b1, 0);
        test_random_phase(5'd1, 1'b0, 0);
        test_random_phase(5'd0, 1'b0, 0);
        test_random_phase(5'd17, 1'b0, 40);
        test_random_phase(5'd2, 1'b0, 0);
        test_random_phase(5'd10, 1'b0, 0);
        test_random_phase(5'($urandom_range(16, 1)), 1'b0, 0);
        test_random_phase(5'd31, 1'b0, 0);

        drain_and_settle();
        if (error_count == 0) begin
            $display("tb_ordered_list_with_compaction: done, clean");
        end else begin
            $display("tb_ordered_list_with_compaction: done, errors");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hdl
hdl/olc_pkg.sv
hdl/olc_seq.sv
hdl/ordered_list_with_compaction.sv
tb/sv/tb_ordered_list_with_compaction.sv
